// ===== hdl/mrac_pkg.sv =====
// Package with the constants and codes shared by the memory region access checker.
`timescale 1ns / 1ps
`default_nettype none

package mrac_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TYPE_W   = 3;
    localparam int unsigned RIGHTS_W = 8;
    localparam int unsigned ATTR_W   = RIGHTS_W + TYPE_W;
    localparam int unsigned MAX_REGIONS = 4;
    localparam int unsigned ATTRS_W  = ATTR_W * MAX_REGIONS;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned BOUNDS_W = 2 * ADDR_W;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 6;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
    localparam logic [OP_W-1:0] OP_VERIFY = 3'd3;
    localparam logic [OP_W-1:0] OP_ABORT  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_SUCCESS = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DENIED  = 2'd3;

    localparam logic [TYPE_W-1:0] TYPE_RAM    = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_FLASH  = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_EEPROM = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_ROM    = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_MIRROR = 3'd4;

    localparam int unsigned RIGHT_READ_BIT  = 0;
    localparam int unsigned RIGHT_WRITE_BIT = 1;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDS0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTRS   = 3'd5;

endpackage

`default_nettype wire

// ===== hdl/mrac_if.sv =====
// Valid/ready channel interfaces for access requests and check results.
`timescale 1ns / 1ps
`default_nettype none

interface mrac_req_if;
    logic                         valid;
    logic                         ready;
    logic [mrac_pkg::OP_W-1:0]    operation;
    logic [mrac_pkg::ADDR_W-1:0]  first_addr;
    logic [mrac_pkg::ADDR_W-1:0]  byte_length;

    modport source (output valid, output operation, output first_addr,
                    output byte_length, input ready);
    modport sink   (input valid, input operation, input first_addr,
                    input byte_length, output ready);
endinterface

interface mrac_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [mrac_pkg::STATUS_W-1:0]  status;
    logic                           range_ok;
    logic                           region_hit;
    logic [mrac_pkg::TYPE_W-1:0]    region_type;
    logic [mrac_pkg::RIGHTS_W-1:0]  region_rights;
    logic [mrac_pkg::STATUS_W-1:0]  last_status;

    modport source (output valid, output status, output range_ok, output region_hit,
                    output region_type, output region_rights, output last_status,
                    input ready);
    modport sink   (input valid, input status, input range_ok, input region_hit,
                    input region_type, input region_rights, input last_status,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/memory_region_access_checker.sv =====
// Memory region access checker: matches each request against the configured regions.
//
//  Channel  Direction  Handshake            Contents
//  i_req    in         valid/ready          operation, first_addr, byte_length
//  o_rsp    out        valid/ready          status, range_ok, region hit/type/rights, last_status
//  APB      in/out     psel/penable/pready  region count, bounds and attributes
//
// One word is accepted every cycle unless the output stalls with the input register full. Its
// result is held in the input register, checked by the region comparators and loaded into the
// result register, from which it can be taken.
// Reset clears the configuration, the last-result register and both valid flags.
// A stalled result holds the result register; one further word waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

module memory_region_access_checker #(
    parameter int unsigned NUM_REGIONS = 4
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    mrac_req_if.sink                             i_req,
    mrac_rsp_if.source                           o_rsp,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [mrac_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire  [mrac_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [mrac_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic [mrac_pkg::COUNT_W-1:0]  r_region_count;
    logic [mrac_pkg::BOUNDS_W-1:0] r_bounds [NUM_REGIONS];
    logic [mrac_pkg::ATTRS_W-1:0]  r_attrs;
    logic [mrac_pkg::STATUS_W-1:0] r_last_result;
    logic [mrac_pkg::STATUS_W-1:0] n_last_result;

    logic                          r_in_valid;
    logic [mrac_pkg::OP_W-1:0]     r_op;
    logic [mrac_pkg::ADDR_W-1:0]   r_addr;
    logic [mrac_pkg::ADDR_W-1:0]   r_len;

    logic                          r_out_valid;
    logic [mrac_pkg::STATUS_W-1:0] r_status;
    logic                          r_range_ok;
    logic                          r_hit;
    logic [mrac_pkg::TYPE_W-1:0]   r_type;
    logic [mrac_pkg::RIGHTS_W-1:0] r_rights;
    logic [mrac_pkg::STATUS_W-1:0] r_last_status;

    logic                          w_cfg_wr;
    logic [mrac_pkg::CFG_IDX_W-1:0] w_cfg_idx;
    logic                          w_out_load;
    logic                          w_in_load;

    logic [mrac_pkg::ADDR_W-1:0]   w_last_addr;
    logic [NUM_REGIONS-1:0]        w_first_s;
    logic [NUM_REGIONS-1:0]        w_first_e;
    logic                          w_hit;
    logic                          w_same;
    logic [mrac_pkg::TYPE_W-1:0]   w_type;
    logic [mrac_pkg::RIGHTS_W-1:0] w_rights;
    logic [mrac_pkg::STATUS_W-1:0] n_status;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[mrac_pkg::CFG_ADDR_W-1:3];

    always_comb begin
        prdata = '0;
        case (w_cfg_idx)
            mrac_pkg::REG_COUNT: begin
                prdata = {{(mrac_pkg::CFG_DATA_W-mrac_pkg::COUNT_W){1'b0}}, r_region_count};
            end
            mrac_pkg::REG_ATTRS: begin
                prdata = {{(mrac_pkg::CFG_DATA_W-mrac_pkg::ATTRS_W){1'b0}}, r_attrs};
            end
            default: begin
                for (int i = 0; i < NUM_REGIONS; i++) begin
                    if (w_cfg_idx == mrac_pkg::CFG_IDX_W'(mrac_pkg::REG_BOUNDS0 + i)) begin
                        prdata = r_bounds[i];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_count <= '0;
            r_attrs        <= '0;
            for (int i = 0; i < NUM_REGIONS; i++) begin
                r_bounds[i] <= '0;
            end
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                mrac_pkg::REG_COUNT: begin
                    r_region_count <= pwdata[mrac_pkg::COUNT_W-1:0];
                end
                mrac_pkg::REG_ATTRS: begin
                    r_attrs <= pwdata[mrac_pkg::ATTRS_W-1:0];
                end
                default: begin
                    for (int i = 0; i < NUM_REGIONS; i++) begin
                        if (w_cfg_idx == mrac_pkg::CFG_IDX_W'(mrac_pkg::REG_BOUNDS0 + i)) begin
                            r_bounds[i] <= pwdata;
                        end
                    end
                end
            endcase
        end
    end

    assign w_out_load  = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign w_in_load   = i_req.valid && i_req.ready;
    assign i_req.ready = !r_in_valid || w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_op   <= i_req.operation;
            r_addr <= i_req.first_addr;
            r_len  <= i_req.byte_length;
        end
    end

    assign w_last_addr = r_addr + r_len - 32'd1;

    always_comb begin
        logic [mrac_pkg::ADDR_W-1:0] lo;
        logic [mrac_pkg::ADDR_W:0]   hi;
        logic                        done_s;
        logic                        done_e;
        done_s    = 1'b0;
        done_e    = 1'b0;
        w_first_s = '0;
        w_first_e = '0;
        w_rights  = '0;
        w_type    = '0;
        for (int i = 0; i < NUM_REGIONS; i++) begin
            lo = r_bounds[i][mrac_pkg::ADDR_W-1:0];
            hi = {1'b0, lo} + {1'b0, r_bounds[i][mrac_pkg::BOUNDS_W-1:mrac_pkg::ADDR_W]};
            if (mrac_pkg::COUNT_W'(i) < r_region_count) begin
                if (!done_s && r_addr >= lo && {1'b0, r_addr} < hi) begin
                    done_s       = 1'b1;
                    w_first_s[i] = 1'b1;
                    w_rights     = r_attrs[mrac_pkg::ATTR_W*i +: mrac_pkg::RIGHTS_W];
                    w_type       = r_attrs[mrac_pkg::ATTR_W*i + mrac_pkg::RIGHTS_W +:
                                           mrac_pkg::TYPE_W];
                end
                if (!done_e && w_last_addr >= lo && {1'b0, w_last_addr} < hi) begin
                    done_e       = 1'b1;
                    w_first_e[i] = 1'b1;
                end
            end
        end
    end

    assign w_hit  = |w_first_s;
    assign w_same = w_hit && (w_first_s == w_first_e);

    always_comb begin
        logic known;
        logic need_read;
        logic granted;
        known         = (w_type <= mrac_pkg::TYPE_MIRROR);
        need_read     = (r_op == mrac_pkg::OP_READ) || (r_op == mrac_pkg::OP_VERIFY);
        granted       = need_read ? w_rights[mrac_pkg::RIGHT_READ_BIT]
                                  : w_rights[mrac_pkg::RIGHT_WRITE_BIT];
        n_status      = mrac_pkg::ST_ERROR;
        n_last_result = r_last_result;
        if (r_op == mrac_pkg::OP_ABORT) begin
            n_last_result = mrac_pkg::ST_ERROR;
        end else if (r_op > mrac_pkg::OP_ABORT || r_len == '0) begin
            n_status = mrac_pkg::ST_ERROR;
        end else if (!w_same) begin
            n_status = mrac_pkg::ST_INVALID;
        end else if (!granted) begin
            n_status = mrac_pkg::ST_DENIED;
        end else begin
            case (r_op)
                mrac_pkg::OP_READ: begin
                    n_status      = known ? mrac_pkg::ST_SUCCESS : mrac_pkg::ST_ERROR;
                    n_last_result = n_status;
                end
                mrac_pkg::OP_WRITE: begin
                    if (!known) begin
                        n_status = mrac_pkg::ST_ERROR;
                    end else if (w_type == mrac_pkg::TYPE_ROM) begin
                        n_status = mrac_pkg::ST_DENIED;
                    end else begin
                        n_status = mrac_pkg::ST_SUCCESS;
                    end
                    n_last_result = n_status;
                end
                mrac_pkg::OP_ERASE: begin
                    n_status = (w_type == mrac_pkg::TYPE_FLASH ||
                                w_type == mrac_pkg::TYPE_EEPROM) ? mrac_pkg::ST_SUCCESS
                                                                 : mrac_pkg::ST_DENIED;
                    n_last_result = n_status;
                end
                default: begin
                    if (known) begin
                        n_status = mrac_pkg::ST_SUCCESS;
                    end else begin
                        n_status      = mrac_pkg::ST_ERROR;
                        n_last_result = mrac_pkg::ST_ERROR;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_last_result <= mrac_pkg::ST_SUCCESS;
        end else begin
            if (w_out_load) begin
                r_out_valid   <= 1'b1;
                r_last_result <= n_last_result;
            end else if (o_rsp.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_status      <= n_status;
            r_range_ok    <= w_same;
            r_hit         <= w_hit;
            r_type        <= w_type;
            r_rights      <= w_rights;
            r_last_status <= n_last_result;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.range_ok      = r_range_ok;
    assign o_rsp.region_hit    = r_hit;
    assign o_rsp.region_type   = r_type;
    assign o_rsp.region_rights = r_rights;
    assign o_rsp.last_status   = r_last_status;

endmodule

`default_nettype wire

// ===== tb/sv/tb_memory_region_access_checker.sv =====
// Self-checking testbench for the memory region access checker, with scoreboard and stimulus.
`timescale 1ns / 1ps

module tb_memory_region_access_checker;

    localparam int LAYOUT_TILED     = 0;
    localparam int LAYOUT_SCATTER   = 1;
    localparam int LAYOUT_SATURATED = 2;
    localparam int LAYOUT_WHOLE     = 3;
    localparam int PHASES           = 8;
    localparam int WORDS_PER_PHASE  = 220;

    typedef struct packed {
        logic [mrac_pkg::STATUS_W-1:0] status;
        logic                          range_ok;
        logic                          region_hit;
        logic [mrac_pkg::TYPE_W-1:0]   region_type;
        logic [mrac_pkg::RIGHTS_W-1:0] region_rights;
        logic [mrac_pkg::STATUS_W-1:0] last_status;
    } t_access_result;

    class t_region_check_model;
        logic [mrac_pkg::COUNT_W-1:0]  live_count;
        logic [mrac_pkg::BOUNDS_W-1:0] live_bounds [mrac_pkg::MAX_REGIONS];
        logic [mrac_pkg::ATTRS_W-1:0]  live_attrs;
        logic [mrac_pkg::STATUS_W-1:0] recorded_status;
        t_access_result                pending_verdicts [$];
        int                            errors;
        int                            checked;
        int                            layouts;
        int                            per_op [8];
        int                            per_status [4];

        function new();
            live_count = '0;
            foreach (live_bounds[i]) live_bounds[i] = '0;
            live_attrs = '0;
            recorded_status = mrac_pkg::ST_SUCCESS;
            errors = 0;
            checked = 0;
            layouts = 0;
        endfunction

        function void set_register(logic [mrac_pkg::CFG_IDX_W-1:0] idx,
                                   logic [mrac_pkg::CFG_DATA_W-1:0] val);
            if (idx == mrac_pkg::REG_COUNT)
                live_count = val[mrac_pkg::COUNT_W-1:0];
            else if (idx == mrac_pkg::REG_ATTRS)
                live_attrs = val[mrac_pkg::ATTRS_W-1:0];
            else if (idx >= mrac_pkg::REG_BOUNDS0 &&
                     idx < mrac_pkg::REG_BOUNDS0 + mrac_pkg::MAX_REGIONS)
                live_bounds[idx - mrac_pkg::REG_BOUNDS0] = val;
        endfunction

        function int match_region(logic [mrac_pkg::ADDR_W-1:0] addr);
            int unsigned               used;
            logic [mrac_pkg::ADDR_W:0] lo;
            logic [mrac_pkg::ADDR_W:0] hi;
            used = (live_count > mrac_pkg::MAX_REGIONS) ? mrac_pkg::MAX_REGIONS
                                                         : 32'(live_count);
            for (int i = 0; i < int'(used); i++) begin
                lo = {1'b0, live_bounds[i][mrac_pkg::ADDR_W-1:0]};
                hi = lo + {1'b0, live_bounds[i][mrac_pkg::BOUNDS_W-1:mrac_pkg::ADDR_W]};
                if ({1'b0, addr} >= lo && {1'b0, addr} < hi) return i;
            end
            return -1;
        endfunction

        function void note_request(logic [mrac_pkg::OP_W-1:0] op,
                                   logic [mrac_pkg::ADDR_W-1:0] addr,
                                   logic [mrac_pkg::ADDR_W-1:0] len);
            t_access_result                r;
            logic [mrac_pkg::ADDR_W-1:0]   last_byte;
            int                            rs;
            int                            re;
            int unsigned                   need;
            logic [mrac_pkg::STATUS_W-1:0] st;
            last_byte = addr + len - mrac_pkg::ADDR_W'(1);
            rs = match_region(addr);
            re = match_region(last_byte);
            r.region_rights = '0;
            r.region_type = '0;
            if (rs >= 0) begin
                r.region_rights = live_attrs[mrac_pkg::ATTR_W*rs +: mrac_pkg::RIGHTS_W];
                r.region_type = live_attrs[mrac_pkg::ATTR_W*rs + mrac_pkg::RIGHTS_W +:
                                           mrac_pkg::TYPE_W];
            end
            r.region_hit = (rs >= 0);
            r.range_ok = (rs >= 0) && (rs == re);
            if (op == mrac_pkg::OP_ABORT) begin
                st = mrac_pkg::ST_ERROR;
                recorded_status = mrac_pkg::ST_ERROR;
            end else if (op > mrac_pkg::OP_ABORT || len == 0) begin
                st = mrac_pkg::ST_ERROR;
            end else if (!r.range_ok) begin
                st = mrac_pkg::ST_INVALID;
            end else begin
                need = (op == mrac_pkg::OP_READ || op == mrac_pkg::OP_VERIFY)
                       ? mrac_pkg::RIGHT_READ_BIT : mrac_pkg::RIGHT_WRITE_BIT;
                if (!r.region_rights[need]) begin
                    st = mrac_pkg::ST_DENIED;
                end else begin
                    case (op)
                        mrac_pkg::OP_READ: begin
                            st = (r.region_type <= mrac_pkg::TYPE_MIRROR)
                                 ? mrac_pkg::ST_SUCCESS : mrac_pkg::ST_ERROR;
                            recorded_status = st;
                        end
                        mrac_pkg::OP_WRITE: begin
                            st = (r.region_type > mrac_pkg::TYPE_MIRROR) ? mrac_pkg::ST_ERROR :
                                 (r.region_type == mrac_pkg::TYPE_ROM) ? mrac_pkg::ST_DENIED
                                                                       : mrac_pkg::ST_SUCCESS;
                            recorded_status = st;
                        end
                        mrac_pkg::OP_ERASE: begin
                            st = (r.region_type == mrac_pkg::TYPE_FLASH ||
                                  r.region_type == mrac_pkg::TYPE_EEPROM)
                                 ? mrac_pkg::ST_SUCCESS : mrac_pkg::ST_DENIED;
                            recorded_status = st;
                        end
                        default: begin
                            st = (r.region_type <= mrac_pkg::TYPE_MIRROR)
                                 ? mrac_pkg::ST_SUCCESS : mrac_pkg::ST_ERROR;
                            if (st == mrac_pkg::ST_ERROR) recorded_status = st;
                        end
                    endcase
                end
            end
            r.status = st;
            r.last_status = recorded_status;
            per_op[op]++;
            per_status[st]++;
            pending_verdicts.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(t_access_result got);
            t_access_result want;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("result with nothing outstanding, status %0d", got.status));
                return;
            end
            want = pending_verdicts.pop_front();
            checked++;
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.range_ok !== want.range_ok)
                report($sformatf("range_ok %0b, want %0b", got.range_ok, want.range_ok));
            if (got.region_hit !== want.region_hit)
                report($sformatf("region_hit %0b, want %0b", got.region_hit, want.region_hit));
            if (got.region_type !== want.region_type)
                report($sformatf("region_type %0d, want %0d", got.region_type, want.region_type));
            if (got.region_rights !== want.region_rights)
                report($sformatf("region_rights %h, want %h",
                                 got.region_rights, want.region_rights));
            if (got.last_status !== want.last_status)
                report($sformatf("last_status %0d, want %0d", got.last_status, want.last_status));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [mrac_pkg::CFG_ADDR_W-1:0] paddr;
    logic [mrac_pkg::CFG_DATA_W-1:0] pwdata;
    logic [mrac_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    mrac_req_if req_bus ();
    mrac_rsp_if rsp_bus ();

    t_region_check_model sb;
    t_access_result      seen;
    int tx_idle_pct;
    int rx_idle_pct;

    memory_region_access_checker uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                seen.status = rsp_bus.status;
                seen.range_ok = rsp_bus.range_ok;
                seen.region_hit = rsp_bus.region_hit;
                seen.region_type = rsp_bus.region_type;
                seen.region_rights = rsp_bus.region_rights;
                seen.last_status = rsp_bus.last_status;
                sb.check_result(seen);
            end
            rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_req(input logic [mrac_pkg::OP_W-1:0] op,
                            input logic [mrac_pkg::ADDR_W-1:0] addr,
                            input logic [mrac_pkg::ADDR_W-1:0] len);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.operation <= op;
        req_bus.first_addr <= addr;
        req_bus.byte_length <= len;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        sb.note_request(op, addr, len);
    endtask

    task automatic stop_req();
        req_bus.valid <= 1'b0;
    endtask

    task automatic settle();
        while (sb.pending_verdicts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mrac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mrac_pkg::CFG_DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_register(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [mrac_pkg::CFG_IDX_W-1:0] bounds_idx(input int i);
        return mrac_pkg::CFG_IDX_W'(32'(mrac_pkg::REG_BOUNDS0) + i);
    endfunction

    function automatic logic [mrac_pkg::ATTR_W-1:0] pack_attr(
            input logic [mrac_pkg::RIGHTS_W-1:0] rights,
            input logic [mrac_pkg::TYPE_W-1:0] kind);
        return {kind, rights};
    endfunction

    function automatic logic [mrac_pkg::ATTR_W-1:0] random_attr();
        logic [mrac_pkg::RIGHTS_W-1:0] rights;
        logic [mrac_pkg::TYPE_W-1:0]   kind;
        rights = mrac_pkg::RIGHTS_W'($urandom);
        rights[mrac_pkg::RIGHT_READ_BIT] = ($urandom_range(3) != 0);
        rights[mrac_pkg::RIGHT_WRITE_BIT] = ($urandom_range(3) != 0);
        kind = ($urandom_range(4) == 0)
               ? mrac_pkg::TYPE_W'(mrac_pkg::TYPE_MIRROR + $urandom_range(1, 3))
               : mrac_pkg::TYPE_W'($urandom_range(0, mrac_pkg::TYPE_MIRROR));
        return pack_attr(rights, kind);
    endfunction

    task automatic program_layout(input int style);
        logic [mrac_pkg::BOUNDS_W-1:0] b [mrac_pkg::MAX_REGIONS];
        logic [mrac_pkg::ATTRS_W-1:0]  at;
        logic [mrac_pkg::COUNT_W-1:0]  cnt;
        logic [mrac_pkg::ADDR_W-1:0]   base;
        logic [mrac_pkg::ADDR_W-1:0]   sz;
        base = $urandom;
        for (int i = 0; i < mrac_pkg::MAX_REGIONS; i++) begin
            sz = ($urandom_range(15) == 0) ? '0 : $urandom_range(1, 16'h4000);
            b[i] = {sz, base};
            base = base + sz + ($urandom_range(1) ? 0 : $urandom_range(0, 64));
            if ($urandom_range(4) == 0) base = base - sz / 2;
            at[mrac_pkg::ATTR_W*i +: mrac_pkg::ATTR_W] = random_attr();
        end
        cnt = ($urandom_range(3) == 0) ? mrac_pkg::COUNT_W'($urandom_range(1, 7))
                                       : mrac_pkg::COUNT_W'(mrac_pkg::MAX_REGIONS);
        case (style)
            LAYOUT_SCATTER: begin
                for (int i = 0; i < mrac_pkg::MAX_REGIONS; i++) b[i] = {$urandom, $urandom};
                at = mrac_pkg::ATTRS_W'({$urandom, $urandom});
                cnt = mrac_pkg::COUNT_W'($urandom);
            end
            LAYOUT_SATURATED: begin
                for (int i = 0; i < mrac_pkg::MAX_REGIONS; i++) b[i] = '1;
                at = '1;
                cnt = '1;
            end
            LAYOUT_WHOLE: begin
                b[mrac_pkg::MAX_REGIONS-1] = {32'hFFFF_FFFF, 32'h0};
                cnt = mrac_pkg::COUNT_W'(mrac_pkg::MAX_REGIONS);
            end
            default: ;
        endcase
        sb.layouts++;
        write_reg(mrac_pkg::REG_COUNT, mrac_pkg::CFG_DATA_W'(cnt));
        for (int i = 0; i < mrac_pkg::MAX_REGIONS; i++) write_reg(bounds_idx(i), b[i]);
        write_reg(mrac_pkg::REG_ATTRS, mrac_pkg::CFG_DATA_W'(at));
    endtask

    function automatic void next_item(output logic [mrac_pkg::OP_W-1:0] op,
                                      output logic [mrac_pkg::ADDR_W-1:0] addr,
                                      output logic [mrac_pkg::ADDR_W-1:0] len);
        int r;
        int k;
        longint unsigned lo;
        longint unsigned sz;
        longint unsigned off;
        longint unsigned room;
        r = $urandom_range(99);
        op = (r < 84) ? mrac_pkg::OP_W'($urandom_range(mrac_pkg::OP_READ, mrac_pkg::OP_VERIFY)) :
             (r < 94) ? mrac_pkg::OP_ABORT
                      : mrac_pkg::OP_W'(mrac_pkg::OP_ABORT + $urandom_range(1, 3));
        k = $urandom_range(mrac_pkg::MAX_REGIONS - 1);
        lo = 64'(sb.live_bounds[k][mrac_pkg::ADDR_W-1:0]);
        sz = 64'(sb.live_bounds[k][mrac_pkg::BOUNDS_W-1:mrac_pkg::ADDR_W]);
        r = $urandom_range(99);
        if (sz == 0 || r >= 85) begin
            addr = $urandom;
            len = (r >= 95) ? $urandom_range(0, 16) : $urandom;
        end else if (r < 60) begin
            off = {$urandom, $urandom} % sz;
            addr = mrac_pkg::ADDR_W'(lo + off);
            room = sz - off;
            case ($urandom_range(2))
                0: len = mrac_pkg::ADDR_W'(room);
                1: len = mrac_pkg::ADDR_W'(1 + ({$urandom, $urandom} % room));
                default: len = mrac_pkg::ADDR_W'(1 + ($urandom % ((room < 64) ? room : 64)));
            endcase
        end else if (r < 75) begin
            addr = mrac_pkg::ADDR_W'(lo + sz - $urandom_range(1, 8));
            len = $urandom_range(2, 64);
        end else begin
            addr = mrac_pkg::ADDR_W'(lo + ({$urandom, $urandom} % sz));
            len = '0;
        end
    endfunction

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [mrac_pkg::OP_W-1:0]   op;
        logic [mrac_pkg::ADDR_W-1:0] addr;
        logic [mrac_pkg::ADDR_W-1:0] len;
        int                          styles [PHASES];
        int                          waited;
        styles = '{LAYOUT_TILED, LAYOUT_WHOLE, LAYOUT_SATURATED, LAYOUT_TILED,
                   LAYOUT_SCATTER, LAYOUT_TILED, LAYOUT_WHOLE, LAYOUT_TILED};
        sb = new();
        tx_idle_pct = 27;
        rx_idle_pct = 69;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_bus.valid = 1'b0;
        req_bus.operation = mrac_pkg::OP_READ;
        req_bus.first_addr = '0;
        req_bus.byte_length = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no regions in use every word misses; abort still records an error.
        send_req(mrac_pkg::OP_READ, 32'h0000_1000, 32'h4);
        send_req(mrac_pkg::OP_ABORT, 32'h0, 32'h0);
        send_req(mrac_pkg::OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        stop_req();
        settle();

        write_reg(mrac_pkg::REG_COUNT, mrac_pkg::CFG_DATA_W'(mrac_pkg::MAX_REGIONS));
        write_reg(bounds_idx(0), {32'h0000_1000, 32'h0000_1000});
        write_reg(bounds_idx(1), {32'h0000_1000, 32'h0000_1800});
        write_reg(bounds_idx(2), {32'h0000_1000, 32'hFFFF_F000});
        write_reg(bounds_idx(3), {32'h0000_0100, 32'h0000_4000});
        write_reg(mrac_pkg::REG_ATTRS, mrac_pkg::CFG_DATA_W'({
                  pack_attr(8'h03, mrac_pkg::TYPE_ROM), pack_attr(8'h03, mrac_pkg::TYPE_EEPROM),
                  pack_attr(8'h02, mrac_pkg::TYPE_FLASH), pack_attr(8'h03, mrac_pkg::TYPE_RAM)}));
        send_req(mrac_pkg::OP_READ, 32'h0000_1000, 32'h0000_1000);
        send_req(mrac_pkg::OP_WRITE, 32'h0000_1000, 32'h1);
        send_req(mrac_pkg::OP_ERASE, 32'h0000_1000, 32'h10);
        send_req(mrac_pkg::OP_VERIFY, 32'h0000_1100, 32'h10);
        send_req(mrac_pkg::OP_READ, 32'h0000_1000, 32'h0);
        send_req(mrac_pkg::OP_READ, 32'h0000_1FF0, 32'h20);
        send_req(mrac_pkg::OP_READ, 32'h0000_2000, 32'h4);
        send_req(mrac_pkg::OP_ERASE, 32'h0000_2000, 32'h800);
        send_req(mrac_pkg::OP_WRITE, 32'h0000_2000, 32'h800);
        send_req(mrac_pkg::OP_WRITE, 32'h0000_4000, 32'h100);
        send_req(mrac_pkg::OP_READ, 32'h0000_4000, 32'h101);
        send_req(mrac_pkg::OP_ERASE, 32'hFFFF_F000, 32'h1000);
        send_req(mrac_pkg::OP_READ, 32'hFFFF_FFF0, 32'h20);
        send_req(mrac_pkg::OP_READ, 32'hFFFF_FFFF, 32'h1);
        send_req(mrac_pkg::OP_ABORT, 32'h0000_1000, 32'h5);
        send_req(mrac_pkg::OP_W'(mrac_pkg::OP_ABORT + 1), 32'h0000_2000, 32'h1);
        send_req(mrac_pkg::OP_W'(mrac_pkg::OP_ABORT + 2), 32'h0, 32'h0);
        send_req(mrac_pkg::OP_W'(mrac_pkg::OP_ABORT + 3), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        stop_req();
        settle();

        // Unknown type on the last region, read-only mirror, and a region with no rights.
        write_reg(mrac_pkg::REG_ATTRS, mrac_pkg::CFG_DATA_W'({
                  pack_attr(8'hFF, mrac_pkg::TYPE_W'(mrac_pkg::TYPE_MIRROR + 3)),
                  pack_attr(8'h00, mrac_pkg::TYPE_EEPROM),
                  pack_attr(8'h03, mrac_pkg::TYPE_FLASH),
                  pack_attr(8'h01, mrac_pkg::TYPE_MIRROR)}));
        send_req(mrac_pkg::OP_READ, 32'h0000_4000, 32'h1);
        send_req(mrac_pkg::OP_VERIFY, 32'h0000_4000, 32'h1);
        send_req(mrac_pkg::OP_WRITE, 32'h0000_4000, 32'h1);
        send_req(mrac_pkg::OP_ERASE, 32'h0000_4000, 32'h1);
        send_req(mrac_pkg::OP_WRITE, 32'h0000_1000, 32'h4);
        send_req(mrac_pkg::OP_READ, 32'h0000_1000, 32'h4);
        send_req(mrac_pkg::OP_VERIFY, 32'h0000_2000, 32'h1);
        send_req(mrac_pkg::OP_WRITE, 32'hFFFF_F000, 32'h1);
        stop_req();

        for (int p = 0; p < PHASES; p++) begin
            case (p / 3)
                0: begin
                    tx_idle_pct = 27;
                    rx_idle_pct = 69;
                end
                1: begin
                    tx_idle_pct = 69;
                    rx_idle_pct = 27;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            settle();
            program_layout(styles[p]);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                next_item(op, addr, len);
                send_req(op, addr, len);
            end
            stop_req();
        end

        waited = 0;
        while (sb.pending_verdicts.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.pending_verdicts.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_verdicts.size()));

        $display("Checked %0d words over %0d region layouts: %0d reads, %0d writes, %0d erases,",
                 sb.checked, sb.layouts + 2, sb.per_op[mrac_pkg::OP_READ],
                 sb.per_op[mrac_pkg::OP_WRITE], sb.per_op[mrac_pkg::OP_ERASE]);
        $display("%0d verifies, %0d aborts, %0d unused codes; %0d success, %0d error, %s",
                 sb.per_op[mrac_pkg::OP_VERIFY], sb.per_op[mrac_pkg::OP_ABORT],
                 sb.per_op[5] + sb.per_op[6] + sb.per_op[7],
                 sb.per_status[mrac_pkg::ST_SUCCESS], sb.per_status[mrac_pkg::ST_ERROR],
                 $sformatf("%0d invalid, %0d denied.", sb.per_status[mrac_pkg::ST_INVALID],
                           sb.per_status[mrac_pkg::ST_DENIED]));
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
